/* hw/rtl/asctime_date_parser_assert.svh */
// Assertion macros for the asctime date parser.
// Included by files that check their own logic; no other dependencies.
`ifndef ASCTIME_DATE_PARSER_ASSERT_SVH
`define ASCTIME_DATE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ADP_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ADP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/adp_pkg.sv */
// Shared types, codes and name tables for the asctime date parser.
// No dependencies; imported by the parser, the result queue and the top level.
package adp_pkg;

    typedef enum logic [3:0] {
        PH_W0, PH_W1, PH_W2, PH_W3, PH_SK1,
        PH_M1, PH_M2, PH_M3, PH_SK2,
        PH_NUM, PH_DONE, PH_ERR
    } t_phase;

    // Position inside one number: before sign, after sign, within digits
    typedef enum logic [1:0] {
        SUB_START, SUB_SIGNED, SUB_DIGITS
    } t_sub;

    typedef logic signed [14:0] t_num;
    typedef logic [13:0]        t_acc;
    typedef logic [2:0]         t_field;

    localparam int     NUM_FIELDS = 5;
    localparam t_field FLD_DAY    = 3'd0;
    localparam t_field FLD_SECOND = 3'd3;
    localparam t_field FLD_YEAR   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_WDAY  = 2'd1;
    localparam logic [1:0] ST_BAD_MONTH = 2'd2;
    localparam logic [1:0] ST_EARLY     = 2'd3;

    localparam t_acc SAT_MAX = 14'd9999;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [23:0] WDAY_NAMES [7] = '{
        "Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"
    };
    localparam logic [23:0] MONTH_NAMES [12] = '{
        "Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
    };

    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] day_of_week;
        logic [3:0] month_number;
        t_num       day_of_month;
        t_num       hour_value;
        t_num       minute_value;
        t_num       second_value;
        t_num       year_value;
    } t_result;

endpackage

/* hw/rtl/adp_if.sv */
// Valid/ready channel interfaces for the asctime date parser.
// Character channel in, parsed date channel out; no dependencies.
interface adp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface adp_date_if;
    logic              valid;
    logic              ready;
    logic        [1:0] status;
    logic        [2:0] day_of_week;
    logic        [3:0] month_number;
    logic signed [14:0] day_of_month;
    logic signed [14:0] hour_value;
    logic signed [14:0] minute_value;
    logic signed [14:0] second_value;
    logic signed [14:0] year_value;

    modport source (output valid, output status, output day_of_week, output month_number,
                    output day_of_month, output hour_value, output minute_value,
                    output second_value, output year_value, input ready);
    modport sink   (input valid, input status, input day_of_week, input month_number,
                    input day_of_month, input hour_value, input minute_value,
                    input second_value, input year_value, output ready);
endinterface

/* hw/rtl/asctime_date_parser.sv */
// Channel   | Dir | Beat contents
// ----------+-----+-----------------------------------------------------------
// i_in      | in  | char_code, last (one character of the date line)
// o_out     | out | status, day_of_week, month_number, five saturated numbers
//
// One character per cycle: the line state updates in a single pass from the
// state registers back into themselves, and the result of the beat that carries
// last is written to a two-entry output queue in the same cycle.
// The result is then offered on o_out from the queue. Reset is synchronous, active low,
// and returns the parser to the start of a line with an empty queue.
// i_in.ready drops only while both queue entries wait on o_out.
// Top level of the asctime date parser; uses adp_pkg, adp_if, adp_parser,
// adp_out_fifo and the assertion macros header.
`include "asctime_date_parser_assert.svh"

module asctime_date_parser (
    input  logic   i_clk,
    input  logic   i_rst_n,
    adp_char_if.sink   i_in,
    adp_date_if.source o_out
);
    import adp_pkg::*;

    logic    in_accept;
    logic    res_valid;
    logic    queue_full;
    t_result res;
    t_result head;

    assign i_in.ready = !queue_full;
    assign in_accept  = i_in.valid && i_in.ready;

    adp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_char_code (i_in.char_code),
        .i_last      (i_in.last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    adp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (queue_full),
        .o_valid (o_out.valid),
        .i_pop   (o_out.ready),
        .o_data  (head)
    );

    assign o_out.status       = head.status;
    assign o_out.day_of_week  = head.day_of_week;
    assign o_out.month_number = head.month_number;
    assign o_out.day_of_month = head.day_of_month;
    assign o_out.hour_value   = head.hour_value;
    assign o_out.minute_value = head.minute_value;
    assign o_out.second_value = head.second_value;
    assign o_out.year_value   = head.year_value;

    `ADP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_accept && i_in.last, o_out.valid, "final character gave no result")
    `ADP_ASSERT_IMPLY(a_stall_has_pending, i_clk, i_rst_n, !i_in.ready, o_out.valid, "input stalled with no result pending")
    `ADP_ASSERT_IMPLY(a_bad_wday_clean, i_clk, i_rst_n, o_out.valid && o_out.status == ST_BAD_WDAY, o_out.day_of_week == 3'd0 && o_out.month_number == 4'd1 && o_out.year_value == 15'sd0, "bad weekday result carries stale fields")
    `ADP_ASSERT_IMPLY(a_bad_month_clean, i_clk, i_rst_n, o_out.valid && o_out.status == ST_BAD_MONTH, o_out.month_number == 4'd1 && o_out.day_of_month == 15'sd0, "bad month result carries stale fields")

endmodule

/* hw/rtl/adp_parser.sv */
// Per-character line state and its combinational next-state update for the date parser.
// Depends on adp_pkg; emits one result on the beat that carries last.
module adp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_code,
    input  logic             i_last,
    output logic             o_res_valid,
    output adp_pkg::t_result o_res
);
    import adp_pkg::*;

    t_phase     r_phase,  n_phase;
    t_sub       r_sub,    n_sub;
    t_field     r_field,  n_field;
    logic [15:0] r_name,  n_name;
    logic [2:0] r_wday,   n_wday;
    logic [3:0] r_month,  n_month;
    t_acc       r_acc,    n_acc;
    logic       r_neg,    n_neg;
    t_num       r_fields [NUM_FIELDS];
    t_num       n_fields [NUM_FIELDS];
    logic [1:0] r_err,    n_err;

    logic        is_blank, is_digit, is_sign, is_minus;
    logic [23:0] full_name;
    logic        wday_hit, month_hit;
    logic [2:0]  wday_idx;
    logic [3:0]  month_num;
    logic        e_num, num_end, chain;
    t_field      e_field, nf1, nf2;
    t_sub        e_sub;
    t_num        prev_val, sacc;
    logic [16:0] sat_sum;
    t_acc        acc_digits, dval;
    logic        year_started;

    function automatic t_num signed_value(input t_acc m, input logic neg);
        t_num mag;
        mag = t_num'({1'b0, m});
        return neg ? -mag : mag;
    endfunction

    assign is_blank  = (i_char_code == CH_SPACE) || (i_char_code == CH_TAB);
    assign is_digit  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_minus  = (i_char_code == CH_MINUS);
    assign is_sign   = is_minus || (i_char_code == CH_PLUS);
    assign dval      = {10'd0, i_char_code[3:0]};
    assign full_name = {r_name, i_char_code};

    always_comb begin
        wday_hit  = 1'b0;
        wday_idx  = 3'd0;
        month_hit = 1'b0;
        month_num = 4'd1;
        for (int i = 0; i < 7; i++) begin
            if (!wday_hit && WDAY_NAMES[i] == full_name) begin
                wday_hit = 1'b1;
                wday_idx = 3'(i);
            end
        end
        for (int i = 0; i < 12; i++) begin
            if (!month_hit && MONTH_NAMES[i] == full_name) begin
                month_hit = 1'b1;
                month_num = 4'(i + 1);
            end
        end
    end

    // A non-blank after the month gap is the first character of the day number
    assign e_num   = (r_phase == PH_NUM) || (r_phase == PH_SK2 && !is_blank);
    assign e_field = (r_phase == PH_NUM) ? r_field : FLD_DAY;
    assign e_sub   = (r_phase == PH_NUM) ? r_sub : SUB_START;
    assign nf1     = e_field + 3'd1;
    assign nf2     = e_field + 3'd2;
    assign num_end = e_num && !is_digit && !(e_sub == SUB_START && is_sign);
    // A lone sign is the skipped character; the offender starts the next number
    assign chain   = num_end && (e_sub == SUB_SIGNED) && (e_field != FLD_YEAR);

    assign prev_val   = (e_field == FLD_DAY) ? t_num'(0) : r_fields[3'(e_field - 3'd1)];
    assign sacc       = signed_value(r_acc, r_neg);
    assign sat_sum    = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {13'd0, i_char_code[3:0]};
    assign acc_digits = (sat_sum > 17'(SAT_MAX)) ? SAT_MAX : sat_sum[13:0];

    // Next state: phase, field and position inside the number
    always_comb begin
        n_phase = r_phase;
        n_field = r_field;
        n_sub   = r_sub;
        case (r_phase)
            PH_W0:  n_phase = PH_W1;
            PH_W1:  n_phase = PH_W2;
            PH_W2:  n_phase = wday_hit ? PH_W3 : PH_ERR;
            PH_W3:  n_phase = PH_SK1;
            PH_SK1: if (!is_blank) n_phase = PH_M1;
            PH_M1:  n_phase = PH_M2;
            PH_M2:  n_phase = month_hit ? PH_M3 : PH_ERR;
            PH_M3:  n_phase = PH_SK2;
            PH_SK2, PH_NUM: begin
                if (e_num) begin
                    n_phase = PH_NUM;
                    n_field = e_field;
                    if (!num_end) begin
                        n_sub = (e_sub == SUB_START && is_sign) ? SUB_SIGNED : SUB_DIGITS;
                    end else if (chain && is_sign) begin
                        n_field = nf1;
                        n_sub   = SUB_SIGNED;
                    end else if (chain) begin
                        if (nf1 == FLD_YEAR) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_field = nf2;
                            n_sub   = SUB_START;
                        end
                    end else if (e_field == FLD_YEAR) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_field = nf1;
                        n_sub   = SUB_START;
                    end
                end
            end
            PH_DONE, PH_ERR: n_phase = r_phase;
            default: n_phase = PH_ERR;
        endcase
    end

    // Datapath: names, accumulator, sign and number fields
    always_comb begin
        n_name  = r_name;
        n_wday  = r_wday;
        n_month = r_month;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_err   = r_err;
        for (int i = 0; i < NUM_FIELDS; i++) begin
            n_fields[i] = r_fields[i];
        end
        case (r_phase)
            PH_W0: n_name = {8'd0, i_char_code};
            PH_W1, PH_M1: n_name = {r_name[7:0], i_char_code};
            PH_W2: begin
                if (wday_hit) n_wday = wday_idx;
                else          n_err  = ST_BAD_WDAY;
            end
            PH_M2: begin
                if (month_hit) n_month = month_num;
                else           n_err   = ST_BAD_MONTH;
            end
            PH_SK1: if (!is_blank) n_name = {8'd0, i_char_code};
            PH_SK2, PH_NUM: begin
                if (e_num && !num_end) begin
                    if (is_digit) n_acc = (e_sub == SUB_DIGITS) ? acc_digits : dval;
                    else          n_neg = is_minus;
                end else if (num_end) begin
                    n_acc = '0;
                    n_neg = 1'b0;
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        if (3'(i) == e_field) begin
                            n_fields[i] = (e_sub == SUB_DIGITS) ? sacc : prev_val;
                        end
                        if (chain && !is_sign && 3'(i) == nf1) begin
                            n_fields[i] = prev_val;
                        end
                    end
                    if (chain && is_sign) n_neg = is_minus;
                end
            end
            default: n_name = r_name;
        endcase
    end

    // Result, taken from the state as it stands after this character
    assign year_started = (n_phase == PH_DONE) || (n_phase == PH_NUM && n_field == FLD_YEAR);

    always_comb begin
        o_res.day_of_week  = n_wday;
        o_res.month_number = n_month;
        o_res.day_of_month = n_fields[0];
        o_res.hour_value   = n_fields[1];
        o_res.minute_value = n_fields[2];
        o_res.second_value = n_fields[FLD_SECOND];
        o_res.year_value   = n_fields[FLD_YEAR];
        if (n_err != ST_OK) begin
            o_res.status = n_err;
        end else if (!year_started) begin
            o_res.status = ST_EARLY;
        end else begin
            o_res.status = ST_OK;
            if (n_phase == PH_NUM) begin
                o_res.year_value = (n_sub == SUB_DIGITS) ? signed_value(n_acc, n_neg)
                                                         : n_fields[FLD_SECOND];
            end
        end
    end

    assign o_res_valid = i_accept && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase <= PH_W0;
            r_sub   <= SUB_START;
            r_field <= FLD_DAY;
            r_name  <= '0;
            r_wday  <= '0;
            r_month <= 4'd1;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_err   <= ST_OK;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_fields[i] <= '0;
            end
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_field <= n_field;
            r_name  <= n_name;
            r_wday  <= n_wday;
            r_month <= n_month;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_err   <= n_err;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_fields[i] <= n_fields[i];
            end
        end
    end

endmodule

/* hw/rtl/adp_out_fifo.sv */
// Small result queue that decouples the parser from the output channel.
// Depends on adp_pkg for the result type and depth.
module adp_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  adp_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output adp_pkg::t_result o_data
);
    import adp_pkg::*;

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    t_result            r_mem [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               pop;

    assign o_full  = (r_count == CNT_W'(OUT_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) n_count = r_count + 1'b1;
        else if (!i_push && pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for asctime_date_parser: feeds date lines one character per beat
// and checks each date with the line parser or a typed date. Uses adp_pkg and adp_if.
module tb;
    import adp_pkg::*;

    typedef logic [7:0] t_chars [$];

    localparam logic [23:0] WEEKDAY_TAGS [7] = '{
        "Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"
    };
    localparam logic [23:0] MONTH_TAGS [12] = '{
        "Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
    };

    localparam int RANDOM_CHARS = 1700;
    localparam int HOLD_CYCLES  = 300;

    // Directed lines; the last one is checked against the line parser
    localparam int DIRECTED_ROWS = 4;
    localparam bit DIRECTED_TYPED [DIRECTED_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b0};
    localparam t_result DIRECTED_DATES [DIRECTED_ROWS] = '{
        '{ST_EARLY,     3'd0, 4'd1, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0},
        '{ST_BAD_WDAY,  3'd0, 4'd1, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0},
        '{ST_BAD_MONTH, 3'd6, 4'd1, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0},
        '0
    };
    string directed_text [DIRECTED_ROWS] = '{
        "Sun", "Wen", "Sat\377Dex", "Thu\t Dec -12345:+xx99999"
    };

    logic i_clk;
    logic i_rst_n;

    adp_char_if char_if ();
    adp_date_if date_if ();

    asctime_date_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (date_if)
    );

    // Typed expectation travels with the beat so the monitor sees it at the same edge
    logic    beat_typed;
    t_result beat_date;

    t_result expected_dates [$];
    int      mismatches    = 0;
    int      lines_sent    = 0;
    int      dates_checked = 0;
    bit      rx_holding    = 1'b0;
    bit      tx_steady     = 1'b0;

    // Line parser state
    t_phase      date_phase;
    t_sub        num_pos;
    t_field      num_idx;
    logic [15:0] name_buf;
    logic [2:0]  weekday_seen;
    logic [3:0]  month_seen;
    t_acc        digit_acc;
    logic        minus_seen;
    t_num        date_fields [NUM_FIELDS];
    logic [1:0]  line_error;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void start_line();
        date_phase   = PH_W0;
        num_pos      = SUB_START;
        num_idx      = FLD_DAY;
        name_buf     = '0;
        weekday_seen = '0;
        month_seen   = 4'd1;
        digit_acc    = '0;
        minus_seen   = 1'b0;
        line_error   = ST_OK;
        for (int k = 0; k < NUM_FIELDS; k++) date_fields[k] = '0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int tag_index(input logic [23:0] key, input bit month);
        for (int k = 0; k < 12; k++) begin
            if (!month && k < 7 && WEEKDAY_TAGS[k] == key) return k;
            if (month && MONTH_TAGS[k] == key) return k;
        end
        return -1;
    endfunction

    function automatic t_num earlier_field();
        return (num_idx == FLD_DAY) ? t_num'(0) : date_fields[num_idx - 3'd1];
    endfunction

    function automatic t_num acc_signed();
        t_num mag;
        mag = t_num'({1'b0, digit_acc});
        return minus_seen ? -mag : mag;
    endfunction

    function automatic void close_number(input t_num value);
        date_fields[num_idx] = value;
        digit_acc  = '0;
        minus_seen = 1'b0;
        num_pos    = SUB_START;
        if (num_idx == FLD_YEAR) date_phase = PH_DONE;
        else num_idx = t_field'(num_idx + 3'd1);
    endfunction

    // Returns 1 when the same character has to be parsed again
    function automatic bit feed_char(input logic [7:0] c);
        bit again;
        int hit;
        int wide;
        again = 1'b0;
        case (date_phase)
            PH_W0: begin
                name_buf   = {8'h00, c};
                date_phase = PH_W1;
            end
            PH_W1: begin
                name_buf   = {name_buf[7:0], c};
                date_phase = PH_W2;
            end
            PH_M1: begin
                name_buf   = {name_buf[7:0], c};
                date_phase = PH_M2;
            end
            PH_W2: begin
                hit = tag_index({name_buf, c}, 1'b0);
                if (hit >= 0) begin
                    weekday_seen = 3'(hit);
                    date_phase   = PH_W3;
                end else begin
                    line_error = ST_BAD_WDAY;
                    date_phase = PH_ERR;
                end
            end
            PH_M2: begin
                hit = tag_index({name_buf, c}, 1'b1);
                if (hit >= 0) begin
                    month_seen = 4'(hit + 1);
                    date_phase = PH_M3;
                end else begin
                    line_error = ST_BAD_MONTH;
                    date_phase = PH_ERR;
                end
            end
            PH_W3: date_phase = PH_SK1;
            PH_M3: date_phase = PH_SK2;
            PH_SK1: begin
                if (!is_blank(c)) begin
                    name_buf   = {8'h00, c};
                    date_phase = PH_M1;
                end
            end
            PH_SK2: begin
                if (!is_blank(c)) begin
                    date_phase = PH_NUM;
                    again      = 1'b1;
                end
            end
            PH_NUM: begin
                case (num_pos)
                    SUB_START: begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            minus_seen = (c == CH_MINUS);
                            num_pos    = SUB_SIGNED;
                        end else if (is_digit(c)) begin
                            digit_acc = t_acc'(c - CH_ZERO);
                            num_pos   = SUB_DIGITS;
                        end else begin
                            close_number(earlier_field());
                        end
                    end
                    SUB_SIGNED: begin
                        if (is_digit(c)) begin
                            digit_acc = t_acc'(c - CH_ZERO);
                            num_pos   = SUB_DIGITS;
                        end else begin
                            // the sign was the separator; this character opens the next number
                            again = (num_idx != FLD_YEAR);
                            close_number(earlier_field());
                        end
                    end
                    default: begin
                        if (is_digit(c)) begin
                            wide = int'(digit_acc) * 10 + int'(c - CH_ZERO);
                            digit_acc = (wide > int'(SAT_MAX)) ? SAT_MAX : t_acc'(wide);
                        end else begin
                            close_number(acc_signed());
                        end
                    end
                endcase
            end
            default: ;
        endcase
        return again;
    endfunction

    function automatic t_result close_line();
        t_result r;
        r.status = ST_OK;
        if (line_error != ST_OK) begin
            r.status = line_error;
        end else if (!(date_phase == PH_DONE ||
                       (date_phase == PH_NUM && num_idx == FLD_YEAR))) begin
            r.status = ST_EARLY;
        end else if (date_phase == PH_NUM) begin
            date_fields[FLD_YEAR] = (num_pos == SUB_DIGITS) ? acc_signed() : earlier_field();
        end
        r.day_of_week  = weekday_seen;
        r.month_number = month_seen;
        r.day_of_month = date_fields[0];
        r.hour_value   = date_fields[1];
        r.minute_value = date_fields[2];
        r.second_value = date_fields[3];
        r.year_value   = date_fields[4];
        start_line();
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH date %0d: %s", dates_checked, what);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
    endtask

    always @(posedge i_clk) begin : watch_beats
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (char_if.valid && char_if.ready) begin
                if (feed_char(char_if.char_code)) void'(feed_char(char_if.char_code));
                if (char_if.last) begin
                    want = close_line();
                    expected_dates.push_back(beat_typed ? beat_date : want);
                end
            end
            if (date_if.valid && date_if.ready) begin
                got = {date_if.status, date_if.day_of_week, date_if.month_number,
                       date_if.day_of_month, date_if.hour_value, date_if.minute_value,
                       date_if.second_value, date_if.year_value};
                if (expected_dates.size() == 0) begin
                    report_mismatch("date beat with nothing expected");
                end else begin
                    want = expected_dates.pop_front();
                    check_field("status", int'(got.status), int'(want.status));
                    check_field("day_of_week", int'(got.day_of_week), int'(want.day_of_week));
                    check_field("month_number", int'(got.month_number),
                                int'(want.month_number));
                    check_field("day_of_month", int'(got.day_of_month),
                                int'(want.day_of_month));
                    check_field("hour_value", int'(got.hour_value), int'(want.hour_value));
                    check_field("minute_value", int'(got.minute_value),
                                int'(want.minute_value));
                    check_field("second_value", int'(got.second_value),
                                int'(want.second_value));
                    check_field("year_value", int'(got.year_value), int'(want.year_value));
                end
                dates_checked++;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input bit is_last, input bit typed,
                             input t_result date);
        int gap;
        gap = (tx_steady || rx_holding) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.last      <= is_last;
        beat_typed        <= typed;
        beat_date         <= date;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        if (is_last) lines_sent++;
    endtask

    task automatic send_line(input t_chars text, input bit typed, input t_result date);
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < text.size(); k++)
            send_char(text[k], k == text.size() - 1, typed, date);
    endtask

    function automatic void push_tag(ref t_chars q, input logic [23:0] tag);
        q.push_back(tag[23:16]);
        q.push_back(tag[15:8]);
        q.push_back(tag[7:0]);
    endfunction

    function automatic logic [23:0] random_tag();
        return {8'($urandom_range(65, 122)), 8'($urandom_range(65, 122)),
                8'($urandom_range(65, 122))};
    endfunction

    function automatic logic [7:0] random_blank();
        return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
    endfunction

    function automatic t_chars make_date_line();
        t_chars q;
        int     r;
        int     n;
        r = $urandom_range(0, 99);
        // noise: arbitrary bytes
        if (r < 10) begin
            n = $urandom_range(1, 30);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        r = $urandom_range(0, 24);
        if (r < 22) push_tag(q, WEEKDAY_TAGS[$urandom_range(0, 6)]);
        else if (r == 22) push_tag(q, "Wen");
        else push_tag(q, random_tag());
        q.push_back($urandom_range(0, 9) < 8 ? CH_SPACE : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) q.push_back(random_blank());
        if ($urandom_range(0, 24) < 23) push_tag(q, MONTH_TAGS[$urandom_range(0, 11)]);
        else push_tag(q, random_tag());
        q.push_back($urandom_range(0, 9) < 8 ? CH_SPACE : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) q.push_back(random_blank());
        for (int f = 0; f < NUM_FIELDS; f++) begin
            r = $urandom_range(0, 9);
            if (r == 6 || r == 7) q.push_back(CH_MINUS);
            else if (r == 8) q.push_back(CH_PLUS);
            r = $urandom_range(0, 19);
            n = (r == 0) ? 0 : (r == 1) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if (f < NUM_FIELDS - 1) begin
                r = $urandom_range(0, 9);
                if (r < 5) q.push_back(":");
                else if (r < 8) q.push_back(random_blank());
                else if (r == 8) q.push_back(8'($urandom_range(0, 255)));
                else begin
                    q.push_back(CH_SPACE);
                    q.push_back(CH_SPACE);
                end
            end
        end
        repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(0, 255)));
        // cut some lines short
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, q.size());
            q = q[0:n-1];
        end
        return q;
    endfunction

    initial begin : drive_chars
        t_chars text;
        int     chars_sent;
        int     line_no;
        chars_sent = 0;
        line_no    = 0;
        start_line();
        i_rst_n           <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= '0;
        char_if.last      <= 1'b0;
        beat_typed        <= 1'b0;
        beat_date         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            text.delete();
            for (int k = 0; k < directed_text[row].len(); k++)
                text.push_back(directed_text[row][k]);
            send_line(text, DIRECTED_TYPED[row], DIRECTED_DATES[row]);
        end

        while (chars_sent < RANDOM_CHARS) begin
            // drop valid and drain once mid-run before going on
            if (line_no == 40) begin
                char_if.valid <= 1'b0;
                @(posedge i_clk);
                while (dates_checked < lines_sent) @(posedge i_clk);
            end
            text = make_date_line();
            send_line(text, 1'b0, '0);
            chars_sent += text.size();
            line_no++;
        end
        char_if.valid <= 1'b0;

        while (dates_checked < lines_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d dates never arrived", expected_dates.size()));
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : take_dates
        bit held_once;
        int wait_cycles;
        held_once = 1'b0;
        date_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // hold off long enough for the output queue to fill and stall the input
            if (!held_once && dates_checked >= 12) begin
                held_once  = 1'b1;
                rx_holding = 1'b1;
                date_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_holding = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (wait_cycles > 0) begin
                date_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            date_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!date_if.valid) @(posedge i_clk);
        end
    end

    initial begin : run_limit
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
